// File: sv/sim_pkg.sv
// Shared constants for the small matrix inverse block.
// No dependencies; imported by the top level.
`default_nettype none

package sim_pkg;

    localparam int ENTRY_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int N_ENT           = 9;

    // Product operand indexes per cofactor: c[k] = a[PA_X]*a[PA_Y] - a[PB_X]*a[PB_Y]
    // Entries are numbered row-major, a00 = 0 .. a22 = 8.
    localparam int PA_X [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int PA_Y [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int PB_X [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int PB_Y [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

`default_nettype wire

// File: sv/sim_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow precheck.
// Depends on nothing; instantiated by small_matrix_inverse once per inverse entry.
`default_nettype none

module sim_div #(
    parameter int EW = 32,
    parameter int NW = 97,
    parameter int DW = 99
) (
    input  wire logic          i_clk,
    input  wire logic [EW:0]   i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [EW-1:0] o_q,
    output logic               o_ovf
);

    localparam int RW = ((NW > DW) ? NW : DW) + 1;

    logic [RW-1:0] r_rem [EW+1];
    logic [RW-1:0] r_den [EW+1];
    logic [EW-1:0] r_low [EW+1];
    logic [EW-1:0] r_q   [EW+1];
    logic          r_ovf [EW+1];

    // precheck: quotient needs more than EW bits when num >> EW >= den
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= RW'(i_num >> EW);
            r_den[0] <= RW'(i_den);
            r_low[0] <= i_num[EW-1:0];
            r_q[0]   <= '0;
            r_ovf[0] <= (RW'(i_num >> EW) >= RW'(i_den));
        end
    end

    for (genvar k = 1; k <= EW; k++) begin : g_stage
        logic [RW-1:0] trial;
        logic          ge;
        always_comb begin
            trial = {r_rem[k-1][RW-2:0], r_low[k-1][EW-1]};
            ge    = (trial >= r_den[k-1]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= ge ? (trial - r_den[k-1]) : trial;
                r_den[k] <= r_den[k-1];
                r_low[k] <= r_low[k-1] << 1;
                r_q[k]   <= {r_q[k-1][EW-2:0], ge};
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_q   = r_q[EW];
    assign o_ovf = r_ovf[EW];

endmodule

`default_nettype wire

// File: sv/small_matrix_inverse.sv
// Throughput: one matrix per cycle while the output is not stalled; each entry has its own divider pipeline
// of ENTRY_WIDTH + 1 stages: an overflow precheck, then one quotient bit per stage.
// Stages advance independently, so bubbles close up while the output waits.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only.
// Depends on sim_pkg and sim_div.
`default_nettype none

module small_matrix_inverse
    import sim_pkg::*;
#(
    parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22, zero padding
    input  wire logic [((9*ENTRY_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // func
    input  wire logic [0:0] i_s_axis_tuser,
    output logic      o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    // b00, b01, b02, b10, b11, b12, b20, b21, b22, det_out, zero padding
    output logic [((10*ENTRY_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // ok, clipped
    output logic [1:0] o_m_axis_tuser
);

    localparam int EW = ENTRY_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int PW = 2*EW;
    localparam int CW = 2*EW + 1;
    localparam int DW = 3*EW + 3;
    localparam int NW = CW + 2*FB;
    localparam int HW = 2*EW + 1;
    localparam int NS = EW + 8;
    localparam int SD = 6;

    localparam logic signed [DW-1:0] SMAX = {{(DW-EW+1){1'b0}}, {(EW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = ~SMAX;
    localparam logic [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};

    typedef struct packed {
        logic [EW-1:0]    det;
        logic             dclip;
        logic             nz;
        logic [N_ENT-1:0] neg;
    } t_side;

    logic [NS-1:0] r_v;
    logic [NS-1:0] stage_en;

    always_comb begin
        stage_en[NS-1] = !r_v[NS-1] || i_m_axis_tready;
        for (int k = NS-2; k >= 0; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_en[0]) r_v[0] <= i_s_axis_tvalid;
            for (int k = 1; k < NS; k++) begin
                if (stage_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign o_s_axis_tready = stage_en[0];

    logic signed [EW-1:0] a_in [N_ENT];
    always_comb begin
        for (int k = 0; k < N_ENT; k++) a_in[k] = i_s_axis_tdata[k*EW +: EW];
    end

    // stage 0: all products of the 2x2 minors
    logic signed [PW-1:0] r0_pa [N_ENT];
    logic signed [PW-1:0] r0_pb [N_ENT];
    logic signed [EW-1:0] r0_a  [5];
    logic                 r0_func;

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            for (int k = 0; k < N_ENT; k++) begin
                r0_pa[k] <= a_in[PA_X[k]] * a_in[PA_Y[k]];
                r0_pb[k] <= a_in[PB_X[k]] * a_in[PB_Y[k]];
            end
            for (int k = 0; k < 5; k++) r0_a[k] <= a_in[k];
            r0_func <= i_s_axis_tuser[0];
        end
    end

    // stage 1: cofactors; 2x2 mode takes the swapped / negated entries
    logic signed [CW-1:0] r1_c [N_ENT];
    logic signed [CW-1:0] r1_d2;
    logic signed [EW-1:0] r1_a [3];
    logic                 r1_func;
    logic signed [CW-1:0] m [N_ENT];
    logic signed [CW-1:0] sx [5];

    always_comb begin
        for (int k = 0; k < N_ENT; k++) begin
            m[k] = {r0_pa[k][PW-1], r0_pa[k]} - {r0_pb[k][PW-1], r0_pb[k]};
        end
        for (int k = 0; k < 5; k++) sx[k] = {{(CW-EW){r0_a[k][EW-1]}}, r0_a[k]};
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            if (r0_func) begin
                for (int k = 0; k < N_ENT; k++) r1_c[k] <= m[k];
            end else begin
                for (int k = 0; k < N_ENT; k++) r1_c[k] <= '0;
                r1_c[0] <= sx[4];
                r1_c[1] <= -sx[1];
                r1_c[3] <= -sx[3];
                r1_c[4] <= sx[0];
            end
            r1_d2 <= m[8];
            for (int k = 0; k < 3; k++) r1_a[k] <= r0_a[k];
            r1_func <= r0_func;
        end
    end

    // stage 2: first-row expansion products, cofactor split into two halves
    logic signed [HW-1:0] r2_ph [3];
    logic signed [HW-1:0] r2_pl [3];
    logic signed [CW-1:0] r2_c  [N_ENT];
    logic signed [CW-1:0] r2_d2;
    logic                 r2_func;

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            for (int j = 0; j < 3; j++) begin
                r2_ph[j] <= r1_a[j] * $signed(r1_c[3*j][CW-1:EW]);
                r2_pl[j] <= r1_a[j] * $signed({1'b0, r1_c[3*j][EW-1:0]});
            end
            r2_c    <= r1_c;
            r2_d2   <= r1_d2;
            r2_func <= r1_func;
        end
    end

    // stage 3: recombine the halves
    logic signed [DW-1:0] r3_t [3];
    logic signed [CW-1:0] r3_c [N_ENT];
    logic signed [CW-1:0] r3_d2;
    logic                 r3_func;

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            for (int j = 0; j < 3; j++) begin
                r3_t[j] <= ({{(DW-HW){r2_ph[j][HW-1]}}, r2_ph[j]} << EW)
                         + {{(DW-HW){r2_pl[j][HW-1]}}, r2_pl[j]};
            end
            r3_c    <= r2_c;
            r3_d2   <= r2_d2;
            r3_func <= r2_func;
        end
    end

    // stage 4: determinant
    logic signed [DW-1:0] r4_det;
    logic signed [CW-1:0] r4_c [N_ENT];
    logic                 r4_func;

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r4_det  <= r3_func ? (r3_t[0] + r3_t[1] + r3_t[2])
                               : {{(DW-CW){r3_d2[CW-1]}}, r3_d2};
            r4_c    <= r3_c;
            r4_func <= r3_func;
        end
    end

    // stage 5: magnitudes, signs, scaled determinant
    logic [NW-1:0] r5_num [N_ENT];
    logic [DW-1:0] r5_den;
    t_side         r5_sb;
    logic signed [DW-1:0] dsh;
    logic [CW-1:0]        cmag [N_ENT];
    t_side                sb_n;

    always_comb begin
        dsh = r4_func ? (r4_det >>> (2*FB)) : (r4_det >>> FB);
        sb_n.nz = |r4_det;
        if (dsh > SMAX) begin
            sb_n.det   = EMAX;
            sb_n.dclip = 1'b1;
        end else if (dsh < SMIN) begin
            sb_n.det   = EMIN;
            sb_n.dclip = 1'b1;
        end else begin
            sb_n.det   = dsh[EW-1:0];
            sb_n.dclip = 1'b0;
        end
        for (int k = 0; k < N_ENT; k++) begin
            cmag[k]     = r4_c[k][CW-1] ? -r4_c[k] : r4_c[k];
            sb_n.neg[k] = r4_c[k][CW-1] ^ r4_det[DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            for (int k = 0; k < N_ENT; k++) r5_num[k] <= {cmag[k], {(2*FB){1'b0}}};
            r5_den <= r4_det[DW-1] ? -r4_det : r4_det;
            r5_sb  <= sb_n;
        end
    end

    // stages 6 .. 6+EW: divider bank, sideband travels alongside
    t_side         r_sb [EW+1];
    logic [EW-1:0] div_q   [N_ENT];
    logic          div_ovf [N_ENT];

    for (genvar j = 0; j <= EW; j++) begin : g_sb
        always_ff @(posedge i_clk) begin
            if (stage_en[SD+j]) r_sb[j] <= (j == 0) ? r5_sb : r_sb[(j == 0) ? 0 : j-1];
        end
    end

    for (genvar k = 0; k < N_ENT; k++) begin : g_div
        sim_div #(
            .EW(EW),
            .NW(NW),
            .DW(DW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (stage_en[SD+EW:SD]),
            .i_num (r5_num[k]),
            .i_den (r5_den),
            .o_q   (div_q[k]),
            .o_ovf (div_ovf[k])
        );
    end

    // last stage: sign, saturation, singular case
    logic [EW-1:0]    r_b [N_ENT];
    logic [EW-1:0]    r_det;
    logic             r_ok;
    logic             r_clip;
    logic [EW-1:0]    bval [N_ENT];
    logic [N_ENT-1:0] bsat;
    t_side            sb_l;

    always_comb begin
        sb_l = r_sb[EW];
        for (int k = 0; k < N_ENT; k++) begin
            if (sb_l.neg[k]) begin
                bsat[k] = div_ovf[k] || (div_q[k] > EMIN);
                bval[k] = bsat[k] ? EMIN : -div_q[k];
            end else begin
                bsat[k] = div_ovf[k] || div_q[k][EW-1];
                bval[k] = bsat[k] ? EMAX : div_q[k];
            end
            if (!sb_l.nz) begin
                bval[k] = '0;
                bsat[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[NS-1]) begin
            r_b    <= bval;
            r_det  <= sb_l.det;
            r_ok   <= sb_l.nz;
            r_clip <= sb_l.nz && (sb_l.dclip || (|bsat));
        end
    end

    always_comb begin
        o_m_axis_tdata = '0;
        for (int k = 0; k < N_ENT; k++) o_m_axis_tdata[k*EW +: EW] = r_b[k];
        o_m_axis_tdata[N_ENT*EW +: EW] = r_det;
    end

    assign o_m_axis_tvalid = r_v[NS-1];
    assign o_m_axis_tuser  = {r_clip, r_ok};

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0]
        |-> (o_m_axis_tdata[N_ENT*EW-1:0] == '0) && !o_m_axis_tuser[1])
        else $error("singular result with nonzero inverse or clip");

    a_ready_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_v[0])
        else $error("input stalled with empty first stage");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v) && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while pipeline full and output stalled");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] && !i_m_axis_tready |=> r_v[NS-1] && $stable(r_b[0]) && $stable(r_det))
        else $error("output register changed under stall");

endmodule

`default_nettype wire
